// ===== rtl/nns3d_pkg.sv =====
// ----------------------------------------------------------------------------
// nns3d_pkg: shared types and constants for the 3D nearest neighbour search
// Coordinate format, payload structs of both channels, opcode and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package nns3d_pkg;

  // Coordinate format: two's complement fixed point
  localparam int COORD_BITS          = 20;
  localparam int DEFAULT_MAX_ENTRIES = 256;

  // Field widths fixed by the interface
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int OUT_DIST_W  = 42;

  // Distance datapath widths
  localparam int MAG_W  = COORD_BITS;           // |a - b| of two coordinates
  localparam int SQ_W   = 2 * COORD_BITS;       // one squared term
  localparam int SUM_W  = 2 * COORD_BITS + 2;   // exact sum of three terms
  localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_ENTRY_COUNT = 1'b0;      // register index, paddr[2]

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    op_t                opcode;
    logic [INDEX_W-1:0] entry_index;
    coord_t             point_x;
    coord_t             point_y;
    coord_t             point_z;
    coord_t             orig_x;
    coord_t             orig_y;
    coord_t             orig_z;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]    best_index;
    coord_t                best_x;
    coord_t                best_y;
    coord_t                best_z;
    logic [OUT_DIST_W-1:0] best_distance;
  } rsp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    vec3_t search;
    vec3_t orig;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_neighbour_search_3d_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbour_search_3d_top: brute-force 3D nearest neighbour search
// Entry store, pipelined squared-distance unit and first-minimum tracker.
// ----------------------------------------------------------------------------
// A load item (opcode OP_LOAD) writes one entry of the store: the search
// point and the original point paired with it; slots at or above
// MAX_ENTRIES are dropped and a load returns no item. A query item
// (opcode OP_QUERY) scans entries 0 to entry_count-1 (a count of zero acts
// as one, a count above MAX_ENTRIES as MAX_ENTRIES) and returns the lowest
// index at minimum squared Euclidean distance, that entry's original
// coordinates and the distance, saturated to 42 bits. Only written entries
// may be scanned; the store is not cleared at reset. The store has one
// read port and the distance unit takes one entry per cycle through a
// five-stage pipeline (read, difference, square, sum, compare), so a
// query reads its entries one after another. The block takes no item
// while a query is in flight; a finished result waits in the output
// register while new items are taken, and a second query result holds
// until that register is free. entry_count lies at byte address 0 of
// the APB port and resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_search_3d_top
  import nns3d_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire req_t                  req,
  // result channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output rsp_t                       rsp,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] entry_count;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_W'(1);
    end else if (cfg_write) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Read back: only entry_count is mapped, everything else reads as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = APB_DATA_W'(entry_count);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  state_t           state, state_next;
  logic             req_accept;
  logic             load_hit;
  logic             query_start;
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] last_addr;
  logic [IDX_W-1:0] last_addr_next;
  vec3_t            query;
  logic             rsp_load;

  // pipeline control
  logic             rd_vld, rd_last;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  logic             s1_vld, s1_last;
  logic [IDX_W-1:0] s1_idx;
  logic [MAG_W-1:0] s1_mag [3];
  vec3_t            s1_orig;
  logic             s2_vld, s2_last;
  logic [IDX_W-1:0] s2_idx;
  logic [SQ_W-1:0]  s2_sq [3];
  vec3_t            s2_orig;
  logic             s3_vld, s3_last;
  logic [IDX_W-1:0] s3_idx;
  logic [DIST_W-1:0] s3_dist;
  vec3_t            s3_orig;

  assign req_ready   = (state == ST_IDLE);
  assign req_accept  = req_valid && req_ready;
  assign query_start = req_accept && (req.opcode == OP_QUERY);
  assign load_hit    = req_accept && (req.opcode == OP_LOAD) &&
                       ({24'd0, req.entry_index} < MAX_ENTRIES);
  assign rsp_load    = (state == ST_FINISH) && (!rsp_valid || rsp_ready);

  // Clamp the count to 1..MAX_ENTRIES and keep the last index to scan.
  always_comb begin
    if (entry_count == '0) begin
      last_addr_next = '0;
    end else if ({23'd0, entry_count} >= MAX_ENTRIES) begin
      last_addr_next = IDX_W'(MAX_ENTRIES - 1);
    end else begin
      last_addr_next = IDX_W'(entry_count - COUNT_W'(1));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_start) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (addr == last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_vld && s3_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the query point and scan bounds for the whole scan.
  always_ff @(posedge clk) begin
    if (query_start) begin
      query.x   <= req.point_x;
      query.y   <= req.point_y;
      query.z   <= req.point_z;
      last_addr <= last_addr_next;
      addr      <= '0;
    end else if (state == ST_ISSUE) begin
      addr <= addr + IDX_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Entry store: one write port for loads, one registered read port for scans
  // --------------------------------------------------------------------------
  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (load_hit) begin
      mem[IDX_W'(req.entry_index)] <= '{
        search: '{x: req.point_x, y: req.point_y, z: req.point_z},
        orig:   '{x: req.orig_x,  y: req.orig_y,  z: req.orig_z}
      };
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ISSUE) begin
      rd_data <= mem[addr];
    end
  end

  // --------------------------------------------------------------------------
  // Distance unit: difference, square, sum; one entry per cycle
  // --------------------------------------------------------------------------
  logic signed [MAG_W:0] diff [3];
  coord_t                qc   [3];
  coord_t                pc   [3];
  logic [SUM_W-1:0]      sum;

  assign qc[0] = query.x;
  assign qc[1] = query.y;
  assign qc[2] = query.z;
  assign pc[0] = rd_data.search.x;
  assign pc[1] = rd_data.search.y;
  assign pc[2] = rd_data.search.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = (MAG_W+1)'(qc[k]) - (MAG_W+1)'(pc[k]);
    end
  end

  assign sum = SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_ISSUE);
      s1_vld <= rd_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    // read stage tags
    rd_last <= (addr == last_addr);
    rd_idx  <= addr;
    // absolute differences
    s1_last <= rd_last;
    s1_idx  <= rd_idx;
    s1_orig <= rd_data.orig;
    for (int k = 0; k < 3; k++) begin
      s1_mag[k] <= diff[k][MAG_W] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
    end
    // squares
    s2_last <= s1_last;
    s2_idx  <= s1_idx;
    s2_orig <= s1_orig;
    for (int k = 0; k < 3; k++) begin
      s2_sq[k] <= SQ_W'(s1_mag[k] * s1_mag[k]);
    end
    // sum, saturated to the distance width
    s3_last <= s2_last;
    s3_idx  <= s2_idx;
    s3_orig <= s2_orig;
    s3_dist <= (sum > SUM_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : DIST_W'(sum);
  end

  // --------------------------------------------------------------------------
  // First-minimum tracker: entry 0 seeds it, later entries win only if closer
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  vec3_t             best_orig;

  always_ff @(posedge clk) begin
    if (s3_vld && ((s3_idx == '0) || (s3_dist < best_dist))) begin
      best_dist <= s3_dist;
      best_idx  <= s3_idx;
      best_orig <= s3_orig;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.best_index    <= INDEX_W'(best_idx);
      rsp.best_x        <= best_orig.x;
      rsp.best_y        <= best_orig.y;
      rsp.best_z        <= best_orig.z;
      rsp.best_distance <= (best_dist > DIST_W'({OUT_DIST_W{1'b1}})) ?
                           {OUT_DIST_W{1'b1}} : OUT_DIST_W'(best_dist);
    end
  end

endmodule

`default_nettype wire
